// ===== rtl/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// Ashkin-Teller chain energy package
// Opcodes, register indexes, controller states and the command and status
// bundles shared between the controller and the datapath.
// ----------------------------------------------------------------------------
package atce_pkg;

   // Width of the ring length register and of ring positions.
   localparam int LEN_W    = 9;
   // Width of the energy result.
   localparam int ENERGY_W = 32;
   // Width of the walk counter: it must hold a ring length plus two.
   localparam int CNT_W    = 10;
   // Pipeline depth from the last memory read to an updated accumulator.
   localparam int DRAIN_CYCLES = 3;
   // Position of the newest site in the five-site window of a flip.
   localparam int FLIP_LAST_READ = 4;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_TOTAL  = 2'd1,
      OP_FLIP_G = 2'd2,
      OP_FLIP_S = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_CHAIN_LENGTH  = 3'd0,
      REG_COUP_S_NEAR   = 3'd1,
      REG_COUP_S_NEXT   = 3'd2,
      REG_COUP_G_NEAR   = 3'd3,
      REG_COUP_G_NEXT   = 3'd4,
      REG_COUP_ONSITE   = 3'd5,
      REG_COUP_MIX_NEAR = 3'd6,
      REG_COUP_MIX_NEXT = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic req_load;   // capture the accepted request
      logic start;      // set up a walk: load address, clear accumulator
      logic rd;         // read one site and step the address
      logic use_term;   // the site read now completes a term to accumulate
      logic wr;         // store the request's spins at its site
      logic out_load;   // load the result register
   } cmd_type;

   typedef struct packed {
      op_type           op;
      logic             bad;       // write or flip site index not below the ring length
      logic [LEN_W-1:0] ring_len;  // clamped ring length
      logic             clr_busy;  // spin memory clearing pass running
   } status_type;

endpackage

// ===== rtl/atce_spin_mem.sv =====
// ----------------------------------------------------------------------------
// Ashkin-Teller spin memory
// One entry per site holding the S and sigma bits, one registered read and
// one write per cycle, writes ignored during the clearing sweep after reset.
// ----------------------------------------------------------------------------
module atce_spin_mem #(
   parameter int MAX_SITES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         we,
   input  logic [$clog2(MAX_SITES)-1:0] waddr,
   input  logic [1:0]                   wdata,
   input  logic                         re,
   input  logic [$clog2(MAX_SITES)-1:0] raddr,
   output logic [1:0]                   rdata,
   output logic                         clr_busy
);

   localparam int AW = $clog2(MAX_SITES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SITES - 1);

   logic [1:0]    mem [MAX_SITES];
   logic [1:0]    rdata_ff;
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // Sweep every entry to zero (both spins -1) once after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         clr_busy_ff <= (clr_addr_ff != LAST_ADDR);
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 2'b00;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ===== rtl/atce_datapath.sv =====
// ----------------------------------------------------------------------------
// Ashkin-Teller chain energy datapath
// Configuration registers, request capture, ring address generation, a
// five-site spin window, the coupling term adder and the energy accumulator.
// ----------------------------------------------------------------------------
module atce_datapath #(
   parameter int MAX_SITES  = 256,
   parameter int COUP_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [((COUP_WIDTH > 9) ? COUP_WIDTH : 9)-1:0] csr_wdata,
   input  logic [1:0]                        req_opcode,
   input  logic [7:0]                        req_site_index,
   input  logic                              req_spin_s_bit,
   input  logic                              req_spin_g_bit,
   input  atce_pkg::cmd_type                 cmd,
   output atce_pkg::status_type              status,
   output logic signed [atce_pkg::ENERGY_W-1:0] rsp_energy,
   output logic                              rsp_bad_index
);

   localparam int CW    = COUP_WIDTH;
   localparam int TW    = COUP_WIDTH + 4;
   localparam int AW    = $clog2(MAX_SITES);
   localparam int LW    = atce_pkg::LEN_W;
   localparam int EW    = atce_pkg::ENERGY_W;
   localparam int CAP   = (MAX_SITES > 511) ? 511 : MAX_SITES;
   localparam logic [LW-1:0] LEN_CAP = LW'(CAP);
   localparam logic [LW-1:0] LEN_MIN = LW'(3);
   localparam logic [LW-1:0] LEN_RST = LW'(256);

   // Configuration registers.
   logic [LW-1:0]          chain_len_ff;
   logic signed [CW-1:0]   coup_ff [7];

   // Captured request.
   atce_pkg::op_type       op_ff;
   logic [7:0]             idx_ff;
   logic                   spin_s_ff;
   logic                   spin_g_ff;

   // Walk state.
   logic [LW-1:0]          addr_ff, addr_in;
   logic [4:0]             ws_ff, wg_ff;
   logic                   rd_q_ff, use_q_ff, use_qq_ff, use_qqq_ff;
   logic signed [TW-1:0]   term_ff;
   logic                   neg_ff;
   logic signed [EW-1:0]   acc_ff;
   logic signed [EW-1:0]   energy_ff;
   logic                   bad_ff;

   logic [LW-1:0]          ring_len;
   logic                   bad;
   logic [LW:0]            flip_sum;
   logic [LW-1:0]          flip_start;
   logic [LW-1:0]          addr_inc;
   logic [1:0]             mem_rdata;
   logic                   clr_busy;
   logic signed [CW-1:0]   tc [7];
   logic                   tb [7];
   logic signed [TW-1:0]   term_sum;
   logic                   term_neg;
   logic signed [EW-1:0]   acc_ext;
   logic signed [EW-1:0]   acc_add;

   function automatic logic signed [CW:0] signed_coup(logic signed [CW-1:0] c, logic pos);
      logic signed [CW:0] w;
      w = (CW+1)'(c);
      return pos ? w : -w;
   endfunction

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_len_ff <= LEN_RST;
         for (int k = 0; k < 7; k++) begin
            coup_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (atce_pkg::reg_index_type'(csr_index))
            atce_pkg::REG_CHAIN_LENGTH:  chain_len_ff <= csr_wdata[LW-1:0];
            atce_pkg::REG_COUP_S_NEAR:   coup_ff[0] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_S_NEXT:   coup_ff[1] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_G_NEAR:   coup_ff[2] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_G_NEXT:   coup_ff[3] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_ONSITE:   coup_ff[4] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_MIX_NEAR: coup_ff[5] <= csr_wdata[CW-1:0];
            atce_pkg::REG_COUP_MIX_NEXT: coup_ff[6] <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (chain_len_ff < LEN_MIN) begin
         ring_len = LEN_MIN;
      end else if (chain_len_ff > LEN_CAP) begin
         ring_len = LEN_CAP;
      end else begin
         ring_len = chain_len_ff;
      end
   end

   // --------------------------------------------------------------- request
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff     <= atce_pkg::op_type'(req_opcode);
         idx_ff    <= req_site_index;
         spin_s_ff <= req_spin_s_bit;
         spin_g_ff <= req_spin_g_bit;
      end
   end

   assign bad = (op_ff != atce_pkg::OP_TOTAL) && ({1'b0, idx_ff} >= ring_len);

   // ------------------------------------------------------------- addresses
   // A flip walks from two sites behind the flipped one; the total walks from
   // site zero and wraps once to pick up the last two neighbors.
   assign flip_sum   = (LW+1)'(idx_ff) + (LW+1)'(ring_len) - (LW+1)'(2);
   assign flip_start = (flip_sum >= (LW+1)'(ring_len)) ?
                       LW'(flip_sum - (LW+1)'(ring_len)) : LW'(flip_sum);
   assign addr_inc   = (addr_ff + 1'b1 == ring_len) ? '0 : addr_ff + 1'b1;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.start) begin
         addr_in = (op_ff == atce_pkg::OP_TOTAL) ? '0 : flip_start;
      end else if (cmd.rd) begin
         addr_in = addr_inc;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   atce_spin_mem #(
      .MAX_SITES (MAX_SITES)
   ) u_spin_mem (
      .clock    (clock),
      .reset    (reset),
      .we       (cmd.wr),
      .waddr    (AW'(idx_ff)),
      .wdata    ({spin_s_ff, spin_g_ff}),
      .re       (cmd.rd),
      .raddr    (AW'(addr_ff)),
      .rdata    (mem_rdata),
      .clr_busy (clr_busy)
   );

   // ---------------------------------------------------------------- window
   // Bit 4 is the newest site; for a flip bit 2 is the flipped site.
   always_ff @(posedge clock) begin
      if (rd_q_ff) begin
         ws_ff <= {mem_rdata[1], ws_ff[4:1]};
         wg_ff <= {mem_rdata[0], wg_ff[4:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_q_ff    <= 1'b0;
         use_q_ff   <= 1'b0;
         use_qq_ff  <= 1'b0;
         use_qqq_ff <= 1'b0;
      end else begin
         rd_q_ff    <= cmd.rd;
         use_q_ff   <= cmd.rd & cmd.use_term;
         use_qq_ff  <= use_q_ff;
         use_qqq_ff <= use_qq_ff;
      end
   end

   // ------------------------------------------------------------------ term
   // Seven signed couplings per term. For the total each sign is the product
   // of the two spins of a bond at site two of the window, and the sum enters
   // negated. For a flip the signs are the other spins of each term and the sum is
   // scaled by twice the flipped spin.
   always_comb begin
      unique case (op_ff)
         atce_pkg::OP_FLIP_G: begin
            tc[0] = coup_ff[2]; tb[0] = wg_ff[3];
            tc[1] = coup_ff[2]; tb[1] = wg_ff[1];
            tc[2] = coup_ff[3]; tb[2] = wg_ff[4];
            tc[3] = coup_ff[3]; tb[3] = wg_ff[0];
            tc[4] = coup_ff[4]; tb[4] = ws_ff[2];
            tc[5] = coup_ff[5]; tb[5] = ws_ff[3];
            tc[6] = coup_ff[6]; tb[6] = ws_ff[4];
            term_neg = ~wg_ff[2];
         end
         atce_pkg::OP_FLIP_S: begin
            tc[0] = coup_ff[0]; tb[0] = ws_ff[3];
            tc[1] = coup_ff[0]; tb[1] = ws_ff[1];
            tc[2] = coup_ff[1]; tb[2] = ws_ff[4];
            tc[3] = coup_ff[1]; tb[3] = ws_ff[0];
            tc[4] = coup_ff[4]; tb[4] = wg_ff[2];
            tc[5] = coup_ff[5]; tb[5] = wg_ff[1];
            tc[6] = coup_ff[6]; tb[6] = wg_ff[0];
            term_neg = ~ws_ff[2];
         end
         default: begin
            tc[0] = coup_ff[0]; tb[0] = ws_ff[2] ~^ ws_ff[3];
            tc[1] = coup_ff[1]; tb[1] = ws_ff[2] ~^ ws_ff[4];
            tc[2] = coup_ff[2]; tb[2] = wg_ff[2] ~^ wg_ff[3];
            tc[3] = coup_ff[3]; tb[3] = wg_ff[2] ~^ wg_ff[4];
            tc[4] = coup_ff[4]; tb[4] = ws_ff[2] ~^ wg_ff[2];
            tc[5] = coup_ff[5]; tb[5] = wg_ff[2] ~^ ws_ff[3];
            tc[6] = coup_ff[6]; tb[6] = wg_ff[2] ~^ ws_ff[4];
            term_neg = 1'b1;
         end
      endcase
   end

   always_comb begin
      term_sum = '0;
      for (int k = 0; k < 7; k++) begin
         term_sum = term_sum + TW'(signed_coup(tc[k], tb[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (use_qq_ff) begin
         term_ff <= term_sum;
         neg_ff  <= term_neg;
      end
   end

   // ----------------------------------------------------------- accumulator
   always_comb begin
      acc_ext = EW'(term_ff);
      if (op_ff != atce_pkg::OP_TOTAL) begin
         acc_ext = acc_ext <<< 1;
      end
      acc_add = neg_ff ? -acc_ext : acc_ext;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (use_qqq_ff) begin
         acc_ff <= acc_ff + acc_add;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         energy_ff <= bad ? '0 : acc_ff;
         bad_ff    <= bad;
      end
   end

   assign rsp_energy    = energy_ff;
   assign rsp_bad_index = bad_ff;

   assign status.op       = op_ff;
   assign status.bad      = bad;
   assign status.ring_len = ring_len;
   assign status.clr_busy = clr_busy;

endmodule

// ===== rtl/atce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ashkin-Teller chain energy controller
// Sequences request capture, site writes, memory walks and result delivery.
// ----------------------------------------------------------------------------
module atce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  atce_pkg::status_type status,
   output atce_pkg::cmd_type    cmd
);

   localparam int CW = atce_pkg::CNT_W;

   atce_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       last_read;
   logic                out_free;

   assign last_read = (status.op == atce_pkg::OP_TOTAL) ?
                      CW'(status.ring_len) + CW'(1) : CW'(atce_pkg::FLIP_LAST_READ);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atce_pkg::ST_CLEAR: begin
            if (!status.clr_busy) state_in = atce_pkg::ST_IDLE;
         end
         atce_pkg::ST_IDLE: begin
            if (req_valid) state_in = atce_pkg::ST_DECODE;
         end
         atce_pkg::ST_DECODE: begin
            if (status.bad) begin
               state_in = atce_pkg::ST_FINISH;
            end else if (status.op == atce_pkg::OP_WRITE) begin
               state_in = atce_pkg::ST_IDLE;
            end else begin
               state_in = atce_pkg::ST_READ;
            end
         end
         atce_pkg::ST_READ: begin
            if (cnt_ff == last_read) state_in = atce_pkg::ST_DRAIN;
         end
         atce_pkg::ST_DRAIN: begin
            if (cnt_ff == CW'(atce_pkg::DRAIN_CYCLES - 1)) state_in = atce_pkg::ST_FINISH;
         end
         atce_pkg::ST_FINISH: begin
            if (out_free) state_in = atce_pkg::ST_IDLE;
         end
         default: state_in = atce_pkg::ST_IDLE;
      endcase
   end

   // Outputs and counter.
   always_comb begin
      cmd          = '0;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         atce_pkg::ST_CLEAR: ;
         atce_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_load = req_valid;
         end
         atce_pkg::ST_DECODE: begin
            cnt_in = '0;
            if (!status.bad) begin
               cmd.wr    = (status.op == atce_pkg::OP_WRITE);
               cmd.start = (status.op != atce_pkg::OP_WRITE);
            end
         end
         atce_pkg::ST_READ: begin
            cmd.rd       = 1'b1;
            cmd.use_term = (status.op == atce_pkg::OP_TOTAL) ?
                           (cnt_ff >= CW'(2)) : (cnt_ff == last_read);
            cnt_in       = (cnt_ff == last_read) ? '0 : cnt_ff + 1'b1;
         end
         atce_pkg::ST_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
         end
         atce_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= atce_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/ashkin_teller_chain_energy_unit.sv =====
// A site write returns to idle straight after its decode; a flip reads the five
// sites around the flipped one and a total energy the ring plus two wrapped
// sites, each walk followed by a pipeline drain. One item is in work at a time.
// Throughput is set by the spin memory walk, read one site a cycle, and by rsp_ready.
// Reset is synchronous; afterwards a clearing pass over all MAX_SITES entries
// sets every spin to -1, and no request is taken until it completes.
// ----------------------------------------------------------------------------
// Ashkin-Teller chain energy unit
// Stores a periodic ring of S and sigma spins and computes the ring energy
// or the exact energy change of a single spin flip from Q8.8 couplings as a Q24.8 result.
// ----------------------------------------------------------------------------
module ashkin_teller_chain_energy_unit #(
   parameter int MAX_SITES  = 256,
   parameter int COUP_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Configuration write port.
   input  logic                                        csr_we,
   input  logic [2:0]                                  csr_index,
   input  logic [((COUP_WIDTH > 9) ? COUP_WIDTH : 9)-1:0] csr_wdata,
   // Request channel.
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [1:0]                                  req_opcode,
   input  logic [7:0]                                  req_site_index,
   input  logic                                        req_spin_s_bit,
   input  logic                                        req_spin_g_bit,
   // Result channel.
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [31:0]                          rsp_energy,
   output logic                                        rsp_bad_index
);

   // The controller and the datapath talk only through these two bundles.
   atce_pkg::cmd_type    cmd;
   atce_pkg::status_type status;

   // The controller captures a request when it is idle, then either stores a
   // site, flags a bad index, or runs a walk over the spin memory. A flip
   // walks the five sites centered on the flipped one; the total walks the
   // whole ring plus two wrapped sites so that every bond is seen once.
   atce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the spins, a sliding window of
   // five sites and a three-stage pipeline from memory read to accumulator.
   // The result register frees the controller to take the next transfer
   // while a finished result still waits on the result channel.
   atce_datapath #(
      .MAX_SITES  (MAX_SITES),
      .COUP_WIDTH (COUP_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_opcode     (req_opcode),
      .req_site_index (req_site_index),
      .req_spin_s_bit (req_spin_s_bit),
      .req_spin_g_bit (req_spin_g_bit),
      .cmd            (cmd),
      .status         (status),
      .rsp_energy     (rsp_energy),
      .rsp_bad_index  (rsp_bad_index)
   );

`ifndef NO_ASSERTIONS
   // Only one request is in work at a time: a transfer closes the input side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // A bad index always reports a zero energy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_energy == 32'sd0)
      else $error("bad index result carries a nonzero energy");

   // Right after reset nothing is offered and no request is taken, since
   // the spin memory is then being cleared.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("handshake active directly after reset");
`endif

endmodule

// ===== verif/tb_ashkin_teller_chain_energy_unit.sv =====
// ----------------------------------------------------------------------------
// Ashkin-Teller chain energy unit testbench
// Drives site writes, total energy requests and flip delta requests through
// the request channel. A predictor tracks the spin ring and the coupling
// registers and checks every result against its own energy calculation.
// ----------------------------------------------------------------------------
module tb_ashkin_teller_chain_energy_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SITES     = 256;
   localparam int COUP_WIDTH    = 16;
   localparam int CSR_W         = (COUP_WIDTH > 9) ? COUP_WIDTH : 9;
   // A site write has no result but keeps the block busy after its transfer.
   // This pause covers that with margin.
   localparam int SETTLE_CYCLES = 16;
   // The slowest quiet stretch is the clearing pass after reset, or a total
   // energy over a full ring plus the longest stalls on both sides.
   localparam int STALL_LIMIT   = 4000;

   // One result of the block, as the predictor expects it.
   typedef struct packed {
      logic signed [31:0] energy;
      logic               bad_index;
   } energy_result_type;

   // Clock, reset and every input of the block start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             csr_we    = 1'b0;
   logic [2:0]       csr_index = atce_pkg::REG_CHAIN_LENGTH;
   logic [CSR_W-1:0] csr_wdata = '0;

   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode     = atce_pkg::OP_WRITE;
   logic [7:0] req_site_index = 8'd0;
   logic       req_spin_s_bit = 1'b0;
   logic       req_spin_g_bit = 1'b0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_energy;
   logic               rsp_bad_index;

   // Results that the predictor has worked out and that have not arrived yet.
   energy_result_type expected_results[$];

   // Predictor copy of the configuration registers and of the spin ring.
   logic [8:0]                    model_len;
   logic signed [COUP_WIDTH-1:0]  model_coup [0:6];   // J1 J2 K1 K2 M0 R1 R2
   logic                          model_spin_s [0:MAX_SITES-1];
   logic                          model_spin_g [0:MAX_SITES-1];

   // The settings that the next call to apply_settings will write.
   logic [8:0]                    want_len;
   logic signed [COUP_WIDTH-1:0]  want_coup [0:6];

   // When set, neither side inserts gaps, so transfers go back to back.
   bit steady_flow = 1'b0;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int rsp_hold       = 0;

   always #1 clock = ~clock;

   ashkin_teller_chain_energy_unit #(
      .MAX_SITES  (MAX_SITES),
      .COUP_WIDTH (COUP_WIDTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_site_index (req_site_index),
      .req_spin_s_bit (req_spin_s_bit),
      .req_spin_g_bit (req_spin_g_bit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_energy     (rsp_energy),
      .rsp_bad_index  (rsp_bad_index)
   );

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The ring length register is clamped to the range 3 to MAX_SITES.
   function automatic int ring_sites();
      if (model_len < 3) return 3;
      if (model_len > MAX_SITES) return MAX_SITES;
      return int'(model_len);
   endfunction

   // Stored bit 1 means spin +1 and bit 0 means spin -1.
   function automatic longint spin_s_val(int i);
      return model_spin_s[i] ? 64'sd1 : -64'sd1;
   endfunction

   function automatic longint spin_g_val(int i);
      return model_spin_g[i] ? 64'sd1 : -64'sd1;
   endfunction

   // Sum of all bond and on-site terms around the ring.
   function automatic longint ring_energy(int n);
      longint e;
      int     a;
      int     b;
      e = 0;
      for (int i = 0; i < n; i++) begin
         a = (i + 1) % n;
         b = (i + 2) % n;
         e -= model_coup[0] * spin_s_val(i) * spin_s_val(a)
            + model_coup[1] * spin_s_val(i) * spin_s_val(b)
            + model_coup[2] * spin_g_val(i) * spin_g_val(a)
            + model_coup[3] * spin_g_val(i) * spin_g_val(b)
            + model_coup[4] * spin_s_val(i) * spin_g_val(i)
            + model_coup[5] * spin_g_val(i) * spin_s_val(a)
            + model_coup[6] * spin_g_val(i) * spin_s_val(b);
      end
      return e;
   endfunction

   // Applies one accepted request to the predictor. Returns 1 when the
   // request causes a result, which is then given in res.
   function automatic bit predict_item(input atce_pkg::op_type op,
                                       input logic [7:0] idx,
                                       input logic s, input logic g,
                                       output energy_result_type res);
      int     n;
      int     l;
      int     p1;
      int     p2;
      int     m1;
      int     m2;
      longint e;
      n = ring_sites();
      l = int'(idx);
      res.energy    = '0;
      res.bad_index = 1'b0;
      // The total energy ignores the site index entirely.
      if (op == atce_pkg::OP_TOTAL) begin
         e = ring_energy(n);
         res.energy = e[31:0];
         return 1'b1;
      end
      // Writes and flips outside the ring report an error and store nothing.
      if (l >= n) begin
         res.bad_index = 1'b1;
         return 1'b1;
      end
      if (op == atce_pkg::OP_WRITE) begin
         model_spin_s[l] = s;
         model_spin_g[l] = g;
         return 1'b0;
      end
      p1 = (l + 1) % n;
      p2 = (l + 2) % n;
      m1 = (l + n - 1) % n;
      m2 = (l + n - 2) % n;
      // Flipping a spin negates every term that holds it, so the change is
      // twice the sum of those terms with the sign of the old spin.
      if (op == atce_pkg::OP_FLIP_G) begin
         e = 2 * spin_g_val(l) * (model_coup[2] * (spin_g_val(p1) + spin_g_val(m1))
                                + model_coup[3] * (spin_g_val(p2) + spin_g_val(m2))
                                + model_coup[4] * spin_s_val(l)
                                + model_coup[5] * spin_s_val(p1)
                                + model_coup[6] * spin_s_val(p2));
      end else begin
         e = 2 * spin_s_val(l) * (model_coup[0] * (spin_s_val(p1) + spin_s_val(m1))
                                + model_coup[1] * (spin_s_val(p2) + spin_s_val(m2))
                                + model_coup[4] * spin_g_val(l)
                                + model_coup[5] * spin_g_val(m1)
                                + model_coup[6] * spin_g_val(m2));
      end
      res.energy = e[31:0];
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Every result transfer is compared with the oldest expectation. After
   // each transfer the receiver may lower ready, except in steady flow.
   always @(posedge clock) begin : result_monitor
      energy_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result energy=%0d bad_index=%0b",
                                      rsp_energy, rsp_bad_index));
         end else begin
            want = expected_results.pop_front();
            if (rsp_energy !== want.energy)
               report_mismatch($sformatf("energy got %0d expected %0d",
                                         rsp_energy, want.energy));
            if (rsp_bad_index !== want.bad_index)
               report_mismatch($sformatf("bad_index got %0b expected %0b",
                                         rsp_bad_index, want.bad_index));
         end
         rsp_hold = steady_flow ? 0 : $urandom_range(0, 5);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // The run ends if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("ERROR: watchdog saw no transfer for %0d cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Sends one request and predicts its result at the transfer. Valid is
   // left high after the transfer so that a request without a gap is
   // presented straight after it; a gap or quiesce lowers it.
   task automatic send_item(atce_pkg::op_type op, logic [7:0] idx, logic s, logic g);
      int                gap;
      energy_result_type res;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_site_index <= idx;
      req_spin_s_bit <= s;
      req_spin_g_bit <= g;
      do @(posedge clock); while (!req_ready);
      if (predict_item(op, idx, s, g, res))
         expected_results.push_back(res);
   endtask

   // Waits until every expected result has come, then lets a site write
   // that produced no result finish, so the block is idle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(atce_pkg::reg_index_type r, logic [CSR_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // Writes all eight registers back to back from the wanted settings.
   task automatic apply_settings();
      csr_put(atce_pkg::REG_CHAIN_LENGTH,  {{(CSR_W-9){1'b0}}, want_len});
      csr_put(atce_pkg::REG_COUP_S_NEAR,   want_coup[0]);
      csr_put(atce_pkg::REG_COUP_S_NEXT,   want_coup[1]);
      csr_put(atce_pkg::REG_COUP_G_NEAR,   want_coup[2]);
      csr_put(atce_pkg::REG_COUP_G_NEXT,   want_coup[3]);
      csr_put(atce_pkg::REG_COUP_ONSITE,   want_coup[4]);
      csr_put(atce_pkg::REG_COUP_MIX_NEAR, want_coup[5]);
      csr_put(atce_pkg::REG_COUP_MIX_NEXT, want_coup[6]);
      csr_we <= 1'b0;
      model_len = want_len;
      for (int k = 0; k < 7; k++) model_coup[k] = want_coup[k];
   endtask

   // Couplings are drawn from the extremes, the full range, or small values
   // that keep energies readable.
   function automatic logic signed [COUP_WIDTH-1:0] draw_coupling();
      case ($urandom_range(0, 3))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return COUP_WIDTH'($urandom_range(0, 65535));
         default: return COUP_WIDTH'(int'($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   task automatic randomize_settings(int len_lo, int len_hi);
      quiesce();
      want_len = 9'($urandom_range(len_lo, len_hi));
      for (int k = 0; k < 7; k++) want_coup[k] = draw_coupling();
      apply_settings();
   endtask

   // Random traffic: mostly writes and flips inside the ring, some requests
   // aimed past its end, and a share of total energy requests.
   task automatic run_random_items(int items, int bad_pct, int total_pct);
      atce_pkg::op_type op;
      logic [7:0]       idx;
      int               n;
      for (int k = 0; k < items; k++) begin
         n = ring_sites();
         if ($urandom_range(0, 99) < total_pct) begin
            op = atce_pkg::OP_TOTAL;
         end else begin
            case ($urandom_range(0, 3))
               0, 1:    op = atce_pkg::OP_WRITE;
               2:       op = atce_pkg::OP_FLIP_G;
               default: op = atce_pkg::OP_FLIP_S;
            endcase
         end
         if ($urandom_range(0, 99) < bad_pct)
            idx = (n < MAX_SITES) ? 8'($urandom_range(n, 255)) : 8'($urandom_range(0, 255));
         else
            idx = 8'($urandom_range(0, n - 1));
         send_item(op, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // After reset the ring is all -1 and the couplings are zero, so every
   // energy is zero; the site index of a total energy is ignored.
   task automatic test_reset_state();
      send_item(atce_pkg::OP_TOTAL,  8'hA5, 1'b1, 1'b1);
      send_item(atce_pkg::OP_FLIP_G, 8'hFF, 1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_S, 8'h00, 1'b0, 1'b0);
      send_item(atce_pkg::OP_WRITE,  8'hFF, 1'b1, 1'b1);
      send_item(atce_pkg::OP_WRITE,  8'h00, 1'b0, 1'b1);
   endtask

   // Extreme couplings on the shortest ring, then on a ring whose length
   // register lies beyond MAX_SITES, with wrap-around and bad indexes.
   task automatic test_extreme_couplings();
      quiesce();
      want_len     = 9'd0;             // below three, acts as three
      want_coup[0] = 16'sh8000;
      want_coup[1] = 16'sh7FFF;
      want_coup[2] = 16'sh7FFF;
      want_coup[3] = 16'sh8000;
      want_coup[4] = 16'sh8000;
      want_coup[5] = 16'sh7FFF;
      want_coup[6] = 16'sh8000;
      apply_settings();
      send_item(atce_pkg::OP_WRITE,  8'd0,   1'b1, 1'b0);
      send_item(atce_pkg::OP_WRITE,  8'd1,   1'b0, 1'b1);
      send_item(atce_pkg::OP_WRITE,  8'd2,   1'b1, 1'b1);
      send_item(atce_pkg::OP_WRITE,  8'd3,   1'b0, 1'b0);
      send_item(atce_pkg::OP_WRITE,  8'd255, 1'b1, 1'b1);
      send_item(atce_pkg::OP_FLIP_G, 8'd0,   1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_S, 8'd0,   1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_G, 8'd2,   1'b1, 1'b1);
      send_item(atce_pkg::OP_FLIP_S, 8'd1,   1'b1, 1'b0);
      send_item(atce_pkg::OP_FLIP_S, 8'd3,   1'b0, 1'b1);
      send_item(atce_pkg::OP_FLIP_G, 8'd255, 1'b0, 1'b0);
      send_item(atce_pkg::OP_TOTAL,  8'd0,   1'b0, 1'b0);

      quiesce();
      want_len = 9'd511;               // beyond MAX_SITES, acts as MAX_SITES
      for (int k = 0; k < 7; k++) want_coup[k] = 16'sh8000;
      apply_settings();
      send_item(atce_pkg::OP_WRITE,  8'd255, 1'b1, 1'b1);
      send_item(atce_pkg::OP_WRITE,  8'd254, 1'b0, 1'b1);
      send_item(atce_pkg::OP_FLIP_G, 8'd255, 1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_S, 8'd255, 1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_S, 8'd0,   1'b0, 1'b0);
      send_item(atce_pkg::OP_TOTAL,  8'd0,   1'b0, 1'b0);

      quiesce();
      want_len = 9'd3;
      for (int k = 0; k < 7; k++) want_coup[k] = 16'sh7FFF;
      apply_settings();
      send_item(atce_pkg::OP_TOTAL,  8'd0,   1'b0, 1'b0);
      send_item(atce_pkg::OP_FLIP_G, 8'd1,   1'b0, 1'b0);
   endtask

   // Short rings keep total energies cheap and make wrap-around common.
   task automatic test_small_rings();
      for (int phase = 0; phase < 4; phase++) begin
         randomize_settings(3, 12);
         run_random_items(80, 6, 10);
      end
   endtask

   // A full ring exercises every bit of the site index.
   task automatic test_full_ring();
      for (int phase = 0; phase < 2; phase++) begin
         randomize_settings(256, 511);
         run_random_items(60, 0, 3);
      end
   endtask

   // Both channels transfer on every cycle they can.
   task automatic test_back_to_back();
      randomize_settings(3, 40);
      steady_flow = 1'b1;
      run_random_items(100, 6, 5);
      quiesce();
      steady_flow = 1'b0;
   endtask

   // Any value of the length register, including the clamped ones.
   task automatic test_any_length();
      for (int phase = 0; phase < 2; phase++) begin
         randomize_settings(0, 511);
         run_random_items(40, 10, 4);
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      model_len = 9'd256;
      for (int k = 0; k < 7; k++) model_coup[k] = '0;
      for (int i = 0; i < MAX_SITES; i++) begin
         model_spin_s[i] = 1'b0;
         model_spin_g[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The block clears its spin memory first; the first transfer simply
      // waits for ready.
      test_reset_state();
      test_extreme_couplings();
      test_small_rings();
      test_full_ring();
      test_back_to_back();
      test_any_length();
      quiesce();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
